// ===== hdl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants for the masked popcount contingency
// Field widths, opcodes, register map and the masked popcount helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int CELL_W     = 8;
    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 17;
    localparam int CELLS_W    = 9;
    localparam int POP_W      = 7;
    localparam int SUM_W      = 10;
    localparam int IN_DATA_W  = 264;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] REG_TABLE_CELLS = 3'd0;
    localparam logic [CELLS_W-1:0] TABLE_CELLS_RESET = 9'd27;

    // Table geometry
    localparam int CELL_GROUP      = 3;
    localparam int MAX_CELLS_DEF   = 256;
    // Highest cell an accumulate can touch is 255 + 2
    localparam int REACH_CELLS     = (1 << CELL_W) + CELL_GROUP - 1;

    typedef logic [POP_W-1:0] pop_t;

    // Population count as a balanced adder tree
    function automatic pop_t popcount64(input logic [WORD_W-1:0] w);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
            l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        for (int i = 0; i < 16; i++)
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 8; i++)
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 4; i++)
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        for (int i = 0; i < 2; i++)
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/masked_popcount_contingency.sv =====
// Sequencing: an accumulate item occupies the block through accept, popcount, then
// four steps on the cell RAM: three reads, the second and third overlapped with the
// previous write-back, and the last write. A read item reads its cell at accept, then
// holds the input until the output register is free and loads its counts there. Clear,
// dropped and unused items finish at accept. Each item is done before the next is taken.
// Reset: async active-low; clears control state and all cell valid bits.
// ----------------------------------------------------------------------------
// masked_popcount_contingency: case/control contingency table from popcounts
// Accumulates masked popcounts of three row words into a packed case/control
// cell RAM with saturation; supports clear of cells in use and cell read-out.
// Cells read as zero after reset; table_cells resets to 27. No RAM clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_popcount_contingency #(
    parameter int MAX_CELLS = mcc_pkg::MAX_CELLS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input item stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cell_base[7:0], pattern_word[71:8], row_word_first[135:72],
    // row_word_second[199:136], row_word_third[263:200]
    input  wire logic [mcc_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[1:0], is_control[2]
    input  wire logic [mcc_pkg::IN_USER_W-1:0]   s_tuser,
    // Result item stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // case_count[16:0], control_count[33:17], zero pad[39:34]
    output logic      [mcc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);

    import mcc_pkg::*;

    localparam int DEPTH  = (MAX_CELLS < REACH_CELLS) ? MAX_CELLS : REACH_CELLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int ENTRY_W = 2 * COUNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_RSP  = 3'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Input field split
    logic [OP_W-1:0]   in_opcode;
    logic              in_ctrl;
    logic [CELL_W-1:0] in_base;
    logic [AW-1:0]     in_addr;
    logic [WORD_W-1:0] in_pattern;
    logic [WORD_W-1:0] in_word [3];

    assign in_opcode  = s_tuser[1:0];
    assign in_ctrl    = s_tuser[2];
    assign in_base    = s_tdata[7:0];
    assign in_addr    = AW'(in_base);
    assign in_pattern = s_tdata[71:8];
    assign in_word[0] = s_tdata[135:72];
    assign in_word[1] = s_tdata[199:136];
    assign in_word[2] = s_tdata[263:200];

    // Registers
    logic [2:0]         state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [CELLS_W-1:0] table_cells_reg;
    logic               valid_reg [DEPTH];
    logic               valid_next [DEPTH];
    logic               rd_valid_reg, rd_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_case_reg, out_ctrl_reg;
    logic               ctrl_reg;
    logic [CELL_W-1:0]  base_reg;
    logic [WORD_W-1:0]  masked_reg [3];
    pop_t               pop_reg [3];

    // RAM port signals
    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

    // Effective table size and range checks
    logic [CELLS_W-1:0] lim;
    logic               accept, acc_in_range, rd_in_range, out_load;
    logic [SUM_W-1:0]   in_top, rd_sum, wr_sum;

    assign lim = (int'(table_cells_reg) < MAX_CELLS) ? table_cells_reg
                                                     : CELLS_W'(MAX_CELLS);
    assign accept       = s_tvalid && s_tready;
    assign in_top       = {2'b00, in_base} + SUM_W'(CELL_GROUP);
    assign acc_in_range = (in_top <= {1'b0, lim});
    assign rd_in_range  = ({1'b0, in_base} < lim);
    assign rd_sum       = {2'b00, base_reg} + SUM_W'(step_reg);
    assign wr_sum       = rd_sum - SUM_W'(1);

    // Read-modify-write datapath for the cell being written this cycle
    logic [1:0]         wr_idx;
    logic [ENTRY_W-1:0] old_entry;
    logic [COUNT_W-1:0] old_half;
    logic [COUNT_W:0]   new_sum;
    logic [COUNT_W-1:0] new_half;

    assign wr_idx    = step_reg - 2'd1;
    assign old_entry = rd_valid_reg ? ram_rd_data : '0;
    assign old_half  = ctrl_reg ? old_entry[ENTRY_W-1:COUNT_W] : old_entry[COUNT_W-1:0];
    assign new_sum   = {1'b0, old_half} + (COUNT_W+1)'(pop_reg[wr_idx]);
    assign new_half  = new_sum[COUNT_W] ? COUNT_MAX : new_sum[COUNT_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        valid_next     = valid_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = in_addr;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = wr_sum[AW-1:0];
        ram_wr_data    = ctrl_reg ? {new_half, old_entry[COUNT_W-1:0]}
                                  : {old_entry[ENTRY_W-1:COUNT_W], new_half};
        out_load       = 1'b0;

        // Drop the result once taken
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_opcode)
                        OP_ACCUM:
                        begin
                            if (acc_in_range)
                            begin
                                state_next = ST_POP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (CELLS_W'(i) < lim)
                                begin
                                    valid_next[i] = 1'b0;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            ram_rd_en     = rd_in_range;
                            rd_valid_next = rd_in_range && valid_reg[in_addr];
                            state_next    = ST_RSP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                step_next  = 2'd0;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // Issue the next cell read while writing back the previous one
                if (step_reg != 2'd3)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = rd_sum[AW-1:0];
                    rd_valid_next = valid_reg[rd_sum[AW-1:0]];
                end
                if (step_reg != 2'd0)
                begin
                    ram_wr_en                       = 1'b1;
                    valid_next[wr_sum[AW-1:0]]      = 1'b1;
                end
                if (step_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
                step_next = step_reg + 2'd1;
            end
            ST_RSP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= 2'd0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            table_cells_reg <= TABLE_CELLS_RESET;
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (psel && penable && pwrite && pready && (paddr == REG_TABLE_CELLS))
            begin
                table_cells_reg <= pwdata[CELLS_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= in_ctrl;
            base_reg <= in_base;
            for (int k = 0; k < CELL_GROUP; k++)
            begin
                masked_reg[k] <= in_pattern & in_word[k];
            end
        end
        if (state_reg == ST_POP)
        begin
            for (int k = 0; k < CELL_GROUP; k++)
            begin
                pop_reg[k] <= popcount64(masked_reg[k]);
            end
        end
        if (out_load)
        begin
            out_case_reg <= rd_valid_reg ? ram_rd_data[COUNT_W-1:0] : '0;
            out_ctrl_reg <= rd_valid_reg ? ram_rd_data[ENTRY_W-1:COUNT_W] : '0;
        end
    end

    // Cell RAM: control count in the upper half, case count in the lower half
    mcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - ENTRY_W)'(0), out_ctrl_reg, out_case_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_TABLE_CELLS) ? {(32 - CELLS_W)'(0), table_cells_reg}
                                                 : 32'd0;

    // Checks
    a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (SUM_W'(ram_wr_addr) < {1'b0, lim}))
        else $error("cell write outside the table in use");

    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_opcode == OP_ACCUM) && acc_in_range) |=> !s_tready)
        else $error("new item taken during an accumulate");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== hdl/mcc_ram.sv =====
// ----------------------------------------------------------------------------
// mcc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for masked_popcount_contingency
// Streams accumulate, clear and read items under random idling, tracks every
// case and control cell count in a local table model and checks each read-out
// in order. Table size is rewritten between phases, down to tiny and past max.
// ----------------------------------------------------------------------------

module tb_top;
    import mcc_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED    = 2'd3;
    localparam int                 TBL_DEPTH    = 256;
    localparam int                 DRAIN_CYCLES = 10;
    localparam int                 IDLE_PCT     = 37;
    localparam int                 PHASE_ITEMS  = 30;
    localparam int                 BURST_ITEMS  = 40;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [WORD_W-1:0]  ALL_ONES     = '1;
    localparam logic [WORD_W-1:0]  ODD_BITS     = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [WORD_W-1:0]  EVEN_BITS    = 64'h5555_5555_5555_5555;

    typedef struct {
        logic [OP_W-1:0]   opcode;
        logic              is_control;
        logic [CELL_W-1:0] cell_base;
        logic [WORD_W-1:0] pattern;
        logic [WORD_W-1:0] row0;
        logic [WORD_W-1:0] row1;
        logic [WORD_W-1:0] row2;
    } tbl_item_t;

    typedef struct {
        logic [COUNT_W-1:0] case_cnt;
        logic [COUNT_W-1:0] ctrl_cnt;
    } cell_counts_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // cell_base, pattern_word, row_word_first, row_word_second, row_word_third
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // opcode, is_control
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // case_count, control_count, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    bit no_gaps       = 1'b0;
    int errors        = 0;
    int items_sent    = 0;
    int reads_checked = 0;
    int sizes_used    = 0;

    // Local copy of both count tables and the size register
    logic [COUNT_W-1:0] case_model [TBL_DEPTH];
    logic [COUNT_W-1:0] ctrl_model [TBL_DEPTH];
    logic [CELLS_W-1:0] cells_model;
    cell_counts_t       counts_due [$];
    cell_counts_t       oldest_counts;

    masked_popcount_contingency u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned cells_in_play();
        return (cells_model > TBL_DEPTH) ? TBL_DEPTH : int'(cells_model);
    endfunction

    function automatic logic [COUNT_W-1:0] add_sat(input logic [COUNT_W-1:0] cnt,
                                                   input logic [WORD_W-1:0]  masked);
        int sum;
        sum = int'(cnt) + $countones(masked);
        return (sum > int'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
    endfunction

    // Apply one accepted item to the table model; queue counts for a read
    function automatic void predict_counts(input tbl_item_t it);
        int unsigned       lim;
        int unsigned       base;
        logic [WORD_W-1:0] rows [CELL_GROUP];
        cell_counts_t      rd;
        lim  = cells_in_play();
        base = it.cell_base;
        rows = '{it.row0, it.row1, it.row2};
        case (it.opcode)
            OP_ACCUM:
                if (base + CELL_GROUP <= lim)
                begin
                    for (int k = 0; k < CELL_GROUP; k++)
                    begin
                        if (it.is_control)
                            ctrl_model[base + k] = add_sat(ctrl_model[base + k],
                                                           it.pattern & rows[k]);
                        else
                            case_model[base + k] = add_sat(case_model[base + k],
                                                           it.pattern & rows[k]);
                    end
                end
            OP_CLEAR:
                for (int i = 0; i < lim; i++)
                begin
                    case_model[i] = '0;
                    ctrl_model[i] = '0;
                end
            OP_READ:
            begin
                rd.case_cnt = (base < lim) ? case_model[base] : '0;
                rd.ctrl_cnt = (base < lim) ? ctrl_model[base] : '0;
                counts_due.push_back(rd);
            end
            default: ;
        endcase
    endfunction

    function automatic tbl_item_t make_item(input logic [OP_W-1:0]   opcode,
                                            input logic              is_control,
                                            input logic [CELL_W-1:0] cell_base,
                                            input logic [WORD_W-1:0] pattern,
                                            input logic [WORD_W-1:0] row0,
                                            input logic [WORD_W-1:0] row1,
                                            input logic [WORD_W-1:0] row2);
        tbl_item_t it;
        it.opcode     = opcode;
        it.is_control = is_control;
        it.cell_base  = cell_base;
        it.pattern    = pattern;
        it.row0       = row0;
        it.row1       = row1;
        it.row2       = row2;
        return it;
    endfunction

    // Mix of dense, sparse, full and plain random words
    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return a;
            1:       return ALL_ONES;
            2:       return a & b & {$urandom, $urandom};
            default: return a | b;
        endcase
    endfunction

    // Send one item, with random idle cycles ahead of it unless no_gaps is set
    task automatic send_item(input tbl_item_t it);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.row2, it.row1, it.row0, it.pattern, it.cell_base};
        s_tuser  <= {it.is_control, it.opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_counts(it);
        items_sent++;
    endtask

    // Drop valid, wait for all read-outs, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_cells(input logic [CELLS_W-1:0] cells);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TABLE_CELLS;
        pwdata  <= 32'(cells);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cells_model = cells;
        sizes_used++;
    endtask

    task automatic read_cell(input logic [CELL_W-1:0] cell_idx);
        send_item(make_item(OP_READ, 1'($urandom_range(1)), cell_idx,
                            rand_word(), rand_word(), rand_word(), rand_word()));
    endtask

    // Extremes of the words, edge cells of the reset size, unused opcode, clear
    task automatic test_directed();
        logic [CELL_W-1:0] probe [8];
        probe = '{8'd0, 8'd1, 8'd2, 8'd24, 8'd25, 8'd26, 8'd27, 8'd255};
        read_cell(8'd0);
        send_item(make_item(OP_ACCUM, 1'b0, 8'd0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(make_item(OP_ACCUM, 1'b1, 8'd0, '0, ALL_ONES, ALL_ONES, ALL_ONES));
        // top group of the reset size, two single-bit rows
        send_item(make_item(OP_ACCUM, 1'b1, 8'd24, ALL_ONES, 64'h1,
                            64'h8000_0000_0000_0000, ALL_ONES));
        // groups running past the table are dropped
        send_item(make_item(OP_ACCUM, 1'b0, 8'd25, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(make_item(OP_ACCUM, 1'b1, 8'd255, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(make_item(OP_UNUSED, 1'b1, 8'd0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        // interleaved bits cancel under the mask in the first row
        send_item(make_item(OP_ACCUM, 1'b0, 8'd1, ODD_BITS, EVEN_BITS, ALL_ONES, ODD_BITS));
        foreach (probe[i])
            read_cell(probe[i]);
        send_item(make_item(OP_CLEAR, 1'b0, 8'd0, '0, '0, '0, '0));
        read_cell(8'd0);
        read_cell(8'd26);
    endtask

    // Sizes up to one group; those below one group ignore every accumulate
    task automatic test_small_tables();
        for (int c = 0; c <= CELL_GROUP; c++)
        begin
            write_table_cells(CELLS_W'(c));
            send_item(make_item(OP_ACCUM, 1'b0, 8'd0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
            send_item(make_item(OP_ACCUM, 1'b1, 8'd1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
            read_cell(8'd0);
            read_cell(8'd2);
            read_cell(8'd3);
        end
    endtask

    // Clear touches only the cells in use; sizes past max clamp
    task automatic test_clear_scope();
        write_table_cells(9'd27);
        send_item(make_item(OP_CLEAR, 1'b1, 8'd0, '0, '0, '0, '0));
        send_item(make_item(OP_ACCUM, 1'b0, 8'd3, ALL_ONES, rand_word(), ALL_ONES, 64'hF));
        send_item(make_item(OP_ACCUM, 1'b1, 8'd24, ALL_ONES, 64'hFF, rand_word(), ALL_ONES));
        write_table_cells(9'd9);
        send_item(make_item(OP_CLEAR, 1'b0, 8'd0, '0, '0, '0, '0));
        write_table_cells(9'd27);
        read_cell(8'd3);
        read_cell(8'd5);
        read_cell(8'd24);
        read_cell(8'd26);
        write_table_cells(9'd511);
        send_item(make_item(OP_ACCUM, 1'b1, 8'd253, ALL_ONES, ALL_ONES, 64'h3, ALL_ONES));
        read_cell(8'd253);
        read_cell(8'd255);
    endtask

    // Hammer the smallest full table with dense accumulates, back to back
    task automatic test_burst();
        write_table_cells(9'd3);
        send_item(make_item(OP_CLEAR, 1'b0, 8'd0, '0, '0, '0, '0));
        no_gaps = 1'b1;
        for (int n = 0; n < BURST_ITEMS; n++)
        begin
            send_item(make_item(OP_ACCUM, 1'(n), 8'd0, ALL_ONES, ALL_ONES,
                                rand_word(), ALL_ONES));
            if (n % 10 == 9)
                read_cell(CELL_W'($urandom_range(2)));
        end
        read_cell(8'd0);
        read_cell(8'd1);
        read_cell(8'd2);
        no_gaps = 1'b0;
        settle();
    endtask

    // Mostly in-range accumulates and reads, some noise, per table size
    task automatic test_random();
        logic [CELLS_W-1:0] sizes [8];
        int unsigned        lim;
        int unsigned        counted;
        int unsigned        pick;
        logic [CELL_W-1:0]  base;
        logic [OP_W-1:0]    op;
        sizes = '{9'd256, 9'd81, 9'd9, 9'd511, 9'd243, 9'd2, 9'd27, 9'd3};
        foreach (sizes[p])
        begin
            write_table_cells(sizes[p]);
            lim     = cells_in_play();
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                base = CELL_W'($urandom_range(255));
                op   = OP_READ;
                if (pick < 55)
                begin
                    op = OP_ACCUM;
                    if (lim >= CELL_GROUP)
                        base = CELL_W'($urandom_range(lim - CELL_GROUP));
                end
                else if (pick < 85)
                    base = CELL_W'($urandom_range(lim - 1));
                else if (pick >= 97)
                    op = OP_UNUSED;
                else if (pick >= 93)
                    op = OP_ACCUM;
                else if (pick >= 90)
                    op = OP_CLEAR;
                // the rest reads any cell, in range or not
                if (op == OP_READ || op == OP_CLEAR ||
                    (op == OP_ACCUM && int'(base) + CELL_GROUP <= lim))
                    counted++;
                send_item(make_item(op, 1'($urandom_range(1)), base, rand_word(),
                                    rand_word(), rand_word(), rand_word()));
            end
        end
    endtask

    // Compare each read-out with the oldest predicted counts; stall at random
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (counts_due.size() == 0)
            begin
                $error("unexpected read-out: case_count %0d control_count %0d",
                       m_tdata[COUNT_W-1:0], m_tdata[2*COUNT_W-1:COUNT_W]);
                errors++;
            end
            else
            begin
                oldest_counts = counts_due.pop_front();
                if (m_tdata[COUNT_W-1:0] !== oldest_counts.case_cnt)
                begin
                    $error("case_count: expected %0d, actual %0d",
                           oldest_counts.case_cnt, m_tdata[COUNT_W-1:0]);
                    errors++;
                end
                if (m_tdata[2*COUNT_W-1:COUNT_W] !== oldest_counts.ctrl_cnt)
                begin
                    $error("control_count: expected %0d, actual %0d",
                           oldest_counts.ctrl_cnt, m_tdata[2*COUNT_W-1:COUNT_W]);
                    errors++;
                end
                reads_checked++;
            end
        end
        m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            case_model[i] = '0;
            ctrl_model[i] = '0;
        end
        cells_model = TABLE_CELLS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_tables();
        test_clear_scope();
        test_burst();
        test_random();
        settle();

        $display("ran %0d items over %0d table-size writes, %0d read-outs checked",
                 items_sent, sizes_used, reads_checked);
        $display("covered sizes 0 to 511, clear scope, dropped groups and a gapless burst");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
